### rtl/sao_eo_pkg.sv
// Shared types and constants for the SAO edge-offset filter.
// Used by sao_eo_regs, sao_eo_calc and sao_edge_offset_filter_unit.
// No dependencies.

package sao_eo_pkg;

	localparam int MAX_BLOCK_SIZE = 128;
	localparam int MAX_PIXEL_BITS = 12;

	localparam int PIX_W      = 12;
	localparam int POS_W      = 7;
	localparam int CAT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int OFS_W      = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EO_CLASS       = 3'd0,
		REG_OFFSET_TABLE   = 3'd1,
		REG_SAMPLE_BITS    = 3'd2,
		REG_NEIGHBOR_AVAIL = 3'd3,
		REG_BLOCK_WIDTH    = 3'd4,
		REG_BLOCK_HEIGHT   = 3'd5
	} cfg_reg_t;

	// Edge direction codes
	typedef enum logic [1:0] {
		EO_HOR  = 2'd0,
		EO_VER  = 2'd1,
		EO_D135 = 2'd2,
		EO_D45  = 2'd3
	} eo_class_t;

	// Neighbor availability bit positions
	localparam int AV_LEFT  = 0;
	localparam int AV_RIGHT = 1;
	localparam int AV_UP    = 2;
	localparam int AV_DOWN  = 3;

	typedef struct packed {
		eo_class_t              eo_class;
		logic [CFG_DATA_W-1:0]  offset_table;
		logic [3:0]             sample_bits;
		logic [3:0]             neighbor_avail;
		logic [7:0]             block_width;
		logic [7:0]             block_height;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [PIX_W-1:0] center_pixel;
		logic [PIX_W-1:0] up_pixel;
		logic [PIX_W-1:0] down_pixel;
		logic [PIX_W-1:0] left_pixel;
		logic [PIX_W-1:0] right_pixel;
		logic [PIX_W-1:0] up_left_pixel;
		logic [PIX_W-1:0] up_right_pixel;
		logic [PIX_W-1:0] down_left_pixel;
		logic [PIX_W-1:0] down_right_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [CAT_W-1:0] edge_category;
		logic             filtered;
	} res_t;

endpackage

### rtl/sao_eo_regs.sv
// Configuration register file of the SAO edge-offset filter.
// Depends on sao_eo_pkg for register indexes and the cfg_t layout.

module sao_eo_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sao_eo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sao_eo_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sao_eo_pkg::cfg_t                    cfg
);

	sao_eo_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eo_class       <= sao_eo_pkg::EO_HOR;
			cfg_q.offset_table   <= '0;
			cfg_q.sample_bits    <= 4'd8;
			cfg_q.neighbor_avail <= '0;
			cfg_q.block_width    <= 8'd64;
			cfg_q.block_height   <= 8'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sao_eo_pkg::REG_EO_CLASS:
					cfg_q.eo_class <= sao_eo_pkg::eo_class_t'(cfg_data[1:0]);
				sao_eo_pkg::REG_OFFSET_TABLE:   cfg_q.offset_table   <= cfg_data;
				sao_eo_pkg::REG_SAMPLE_BITS:    cfg_q.sample_bits    <= cfg_data[3:0];
				sao_eo_pkg::REG_NEIGHBOR_AVAIL: cfg_q.neighbor_avail <= cfg_data[3:0];
				sao_eo_pkg::REG_BLOCK_WIDTH:    cfg_q.block_width    <= cfg_data[7:0];
				sao_eo_pkg::REG_BLOCK_HEIGHT:   cfg_q.block_height   <= cfg_data[7:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

endmodule

### rtl/sao_eo_calc.sv
// Single-pass edge-offset computation: range check, category, offset add, clip.
// Purely combinational; depends on sao_eo_pkg for cfg_t, pix_in_t and res_t.

module sao_eo_calc (
	input  sao_eo_pkg::cfg_t     cfg,
	input  sao_eo_pkg::pix_in_t  pix,
	output sao_eo_pkg::res_t     res
);

	localparam logic [7:0] MAX_BLK = 8'(sao_eo_pkg::MAX_BLOCK_SIZE);
	localparam logic [3:0] MAX_BD  = 4'(sao_eo_pkg::MAX_PIXEL_BITS);

	logic [7:0]                      w, h, col_p1, row_p1;
	logic [3:0]                      bd;
	logic                            col_ok, row_ok, in_block, ok;
	logic [sao_eo_pkg::PIX_W-1:0]    a, b, c;
	logic                            gt_a, lt_a, gt_b, lt_b;
	logic [sao_eo_pkg::CAT_W-1:0]    idx;
	logic [sao_eo_pkg::OFS_W-1:0]    ofs;
	logic [sao_eo_pkg::PIX_W:0]      maxv_w;
	logic [sao_eo_pkg::PIX_W-1:0]    maxv;
	logic signed [sao_eo_pkg::PIX_W+1:0] sum;

	always_comb begin
		w  = (cfg.block_width  > MAX_BLK) ? MAX_BLK : cfg.block_width;
		h  = (cfg.block_height > MAX_BLK) ? MAX_BLK : cfg.block_height;
		bd = (cfg.sample_bits > MAX_BD) ? MAX_BD : cfg.sample_bits;

		col_p1 = {1'b0, pix.col} + 8'd1;
		row_p1 = {1'b0, pix.row} + 8'd1;
		col_ok = ((pix.col != '0) || cfg.neighbor_avail[sao_eo_pkg::AV_LEFT]) &&
		         ((col_p1 != w)   || cfg.neighbor_avail[sao_eo_pkg::AV_RIGHT]);
		row_ok = ((pix.row != '0) || cfg.neighbor_avail[sao_eo_pkg::AV_UP]) &&
		         ((row_p1 != h)   || cfg.neighbor_avail[sao_eo_pkg::AV_DOWN]);
		in_block = ({1'b0, pix.row} < h) && ({1'b0, pix.col} < w);

		c = pix.center_pixel;
		unique case (cfg.eo_class)
			sao_eo_pkg::EO_HOR: begin
				a  = pix.left_pixel;
				b  = pix.right_pixel;
				ok = in_block && col_ok;
			end
			sao_eo_pkg::EO_VER: begin
				a  = pix.up_pixel;
				b  = pix.down_pixel;
				ok = in_block && row_ok;
			end
			sao_eo_pkg::EO_D135: begin
				a  = pix.up_left_pixel;
				b  = pix.down_right_pixel;
				ok = in_block && col_ok && row_ok;
			end
			default: begin
				a  = pix.up_right_pixel;
				b  = pix.down_left_pixel;
				ok = in_block && col_ok && row_ok;
			end
		endcase

		gt_a = c > a;
		lt_a = c < a;
		gt_b = c > b;
		lt_b = c < b;
		// category + 2; wraps mod 8 on the way but always lands in 0..4
		idx = 3'd2 + {2'b00, gt_a} - {2'b00, lt_a} + {2'b00, gt_b} - {2'b00, lt_b};

		case (idx)
			3'd0:    ofs = cfg.offset_table[7:0];
			3'd1:    ofs = cfg.offset_table[15:8];
			3'd2:    ofs = cfg.offset_table[23:16];
			3'd3:    ofs = cfg.offset_table[31:24];
			3'd4:    ofs = cfg.offset_table[39:32];
			default: ofs = '0;
		endcase

		maxv_w = ((sao_eo_pkg::PIX_W+1)'(1) << bd) - (sao_eo_pkg::PIX_W+1)'(1);
		maxv   = maxv_w[sao_eo_pkg::PIX_W-1:0];

		sum = $signed({2'b00, c}) + (sao_eo_pkg::PIX_W+2)'($signed(ofs));

		if (!ok) begin
			res.out_pixel     = c;
			res.edge_category = '0;
			res.filtered      = 1'b0;
		end else begin
			if (sum < 0)
				res.out_pixel = '0;
			else if (sum[sao_eo_pkg::PIX_W:0] > {1'b0, maxv})
				res.out_pixel = maxv;
			else
				res.out_pixel = sum[sao_eo_pkg::PIX_W-1:0];
			res.edge_category = idx;
			res.filtered      = 1'b1;
		end
	end

endmodule

### rtl/sao_edge_offset_filter_unit.sv
// Top level of the SAO edge-offset filter: input register, compute, result register.
// Depends on sao_eo_pkg, sao_eo_regs and sao_eo_calc.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per pixel carries its row and
//   column inside the block, the center sample and its eight neighbors.
//   Output channel (out_valid / out_stall): one request per pixel with the
//   filtered sample, the offset index used and the filtered flag.
//   A request moves when valid is high and stall is low at a rising edge.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready
//   is always high; write only while no pixel is in flight. Unknown indexes
//   are dropped.
// Path: an accepted request is held in the input register, computed combinationally,
//   and then registered in the result register that drives the outputs.
// Throughput: one pixel per cycle when the receiver does not stall, set by the two
//   register stages; every pixel is independent of the others.
// Stall: when the receiver stalls, the result register holds; an empty input
//   register still takes one more pixel, after which in_stall rises.
// Reset (arst_n low): pipeline empties, registers return to horizontal class,
//   zero offsets, bit depth 8, no neighbors available, 64x64 block.

module sao_edge_offset_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sao_eo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sao_eo_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sao_eo_pkg::POS_W-1:0]        row,
	input  logic [sao_eo_pkg::POS_W-1:0]        col,
	input  logic [sao_eo_pkg::PIX_W-1:0]        center_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        up_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        down_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        left_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        right_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        up_left_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        up_right_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        down_left_pixel,
	input  logic [sao_eo_pkg::PIX_W-1:0]        down_right_pixel,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sao_eo_pkg::PIX_W-1:0]        out_pixel,
	output logic [sao_eo_pkg::CAT_W-1:0]        edge_category,
	output logic                                filtered
);

	sao_eo_pkg::cfg_t     cfg;
	sao_eo_pkg::pix_in_t  pix_in;
	sao_eo_pkg::pix_in_t  pix_s1;
	sao_eo_pkg::res_t     res_calc;
	sao_eo_pkg::res_t     res_s2;
	logic                 valid_s1, valid_s2;
	logic                 adv_s1, adv_s2;

	sao_eo_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Gather the input ports into one request word
	always_comb begin
		pix_in.row              = row;
		pix_in.col              = col;
		pix_in.center_pixel     = center_pixel;
		pix_in.up_pixel         = up_pixel;
		pix_in.down_pixel       = down_pixel;
		pix_in.left_pixel       = left_pixel;
		pix_in.right_pixel      = right_pixel;
		pix_in.up_left_pixel    = up_left_pixel;
		pix_in.up_right_pixel   = up_right_pixel;
		pix_in.down_left_pixel  = down_left_pixel;
		pix_in.down_right_pixel = down_right_pixel;
	end

	// Result stage advances when empty or drained this cycle; input stage
	// advances when empty or when its content moves on to the result stage.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload: hold while the stage cannot advance
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid)
			pix_s1 <= pix_in;
		if (adv_s2 && valid_s1)
			res_s2 <= res_calc;
	end

	sao_eo_calc u_calc (
		.cfg (cfg),
		.pix (pix_s1),
		.res (res_calc)
	);

	assign out_valid     = valid_s2;
	assign out_pixel     = res_s2.out_pixel;
	assign edge_category = res_s2.edge_category;
	assign filtered      = res_s2.filtered;

`ifndef SYNTHESIS
	// Input backs up only when both stages are full and the receiver stalls
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall raised with room in the pipeline");

	// A pixel in the input stage reaches the outputs next cycle when not stalled
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_stall) |=> out_valid)
		else $error("input stage content lost or delayed");

	// Unfiltered pixels report category index zero
	a_unfilt_cat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !filtered) |-> (edge_category == '0))
		else $error("nonzero category on unfiltered pixel");

	// Category index never leaves the five-entry offset table
	a_cat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (edge_category <= 3'd4))
		else $error("category index out of range");
`endif

endmodule

### sim/tb_sao_edge_offset_filter_unit.sv
// Self-checking testbench for sao_edge_offset_filter_unit: directed probes, then random
// pixels under three idle/stall mixes, each result checked against a local filter model.
// Depends on sao_eo_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_sao_edge_offset_filter_unit;

	localparam int QUIET_LIMIT = 4000;     // cycles with no handshake before giving up
	localparam int PHASE_ITEMS = 333;
	localparam logic [sao_eo_pkg::CFG_DATA_W-1:0] DIR_OFS =
		40'h80_FD_01_03_7F; // -128 -3 +1 +3 +127
	localparam sao_eo_pkg::cfg_t CFG_RESET =
		'{sao_eo_pkg::EO_HOR, 40'd0, 4'd8, 4'd0, 8'd64, 8'd64};

	typedef struct {
		sao_eo_pkg::cfg_t    regs;
		sao_eo_pkg::pix_in_t px;
		bit                  known;   // use the typed result instead of the model
		sao_eo_pkg::res_t    want;
	} probe_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	sao_eo_pkg::cfg_reg_t                 cfg_index = sao_eo_pkg::REG_EO_CLASS;
	logic [sao_eo_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [sao_eo_pkg::POS_W-1:0]   row = '0;
	logic [sao_eo_pkg::POS_W-1:0]   col = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   center_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   up_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   down_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   left_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   right_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   up_left_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   up_right_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   down_left_pixel = '0;
	logic [sao_eo_pkg::PIX_W-1:0]   down_right_pixel = '0;

	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [sao_eo_pkg::PIX_W-1:0]   out_pixel;
	logic [sao_eo_pkg::CAT_W-1:0]   edge_category;
	logic                           filtered;

	sao_eo_pkg::cfg_t regs = CFG_RESET;   // register values the block should hold
	sao_eo_pkg::res_t pixels_due[$];      // filtered pixels still owed, oldest first
	int   failures = 0;
	int   quiet_cycles = 0;
	int   send_gap_pct = 0;
	int   stall_pct = 0;

	// Directed probes: reset state, offset and clip extremes, every edge class and
	// the border rules of each class, positions outside the block, size extremes.
	probe_t probes [25] = '{
		// reset registers: offsets are zero, category +2 passes the centre through
		'{CFG_RESET,
			'{7'd5, 7'd5, 12'd100, 12'd0, 12'd0, 12'd50, 12'd50, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd100, 3'd4, 1'b1}},
		// local minimum gets +127
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd0, 12'd9, 12'd9, 12'd4095, 12'd4095, 12'd9, 12'd9, 12'd9, 12'd9},
			1'b1, '{12'd127, 3'd0, 1'b1}},
		// local maximum gets -128, then clips to the 8-bit ceiling
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd4095, 12'd9, 12'd9, 12'd0, 12'd0, 12'd9, 12'd9, 12'd9, 12'd9},
			1'b1, '{12'd255, 3'd4, 1'b1}},
		// flat area
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd200, 12'd0, 12'd0, 12'd200, 12'd200, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd201, 3'd2, 1'b1}},
		// sum below zero clips to zero
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd50, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd0, 3'd4, 1'b1}},
		// category -1
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd10, 12'd0, 12'd0, 12'd11, 12'd10, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		// horizontal, first column without left neighbor
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h0, 8'd16, 8'd8},
			'{7'd3, 7'd0, 12'd77, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd77, 3'd0, 1'b0}},
		// horizontal, last column without right neighbor
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h0, 8'd16, 8'd8},
			'{7'd3, 7'd15, 12'd78, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd78, 3'd0, 1'b0}},
		// horizontal border columns with left and right available
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h3, 8'd16, 8'd8},
			'{7'd3, 7'd0, 12'd300, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h3, 8'd16, 8'd8},
			'{7'd3, 7'd15, 12'd300, 12'd0, 12'd0, 12'd300, 12'd299, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		// column past the block width
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd16, 12'd79, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd79, 3'd0, 1'b0}},
		// row past the block height
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd8, 7'd3, 12'd80, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd80, 3'd0, 1'b0}},
		// largest position and sample
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd127, 7'd127, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
				12'd0},
			1'b1, '{12'd4095, 3'd0, 1'b0}},
		// vertical, first row without up neighbor
		'{'{sao_eo_pkg::EO_VER, DIR_OFS, 4'd8, 4'h0, 8'd16, 8'd8},
			'{7'd0, 7'd5, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd4095, 3'd0, 1'b0}},
		// vertical border rows with up and down available; column rules do not apply
		'{'{sao_eo_pkg::EO_VER, DIR_OFS, 4'd8, 4'hC, 8'd16, 8'd8},
			'{7'd0, 7'd0, 12'd2000, 12'd10, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
				12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		'{'{sao_eo_pkg::EO_VER, DIR_OFS, 4'd8, 4'hC, 8'd16, 8'd8},
			'{7'd7, 7'd15, 12'd2000, 12'd2001, 12'd2001, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
				12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		// 135 degrees at the top-left corner, all neighbors available
		'{'{sao_eo_pkg::EO_D135, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd0, 7'd0, 12'd500, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd400,
				12'd4095, 12'd4095, 12'd400},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		// 135 degrees, first column without left neighbor
		'{'{sao_eo_pkg::EO_D135, DIR_OFS, 4'd8, 4'hE, 8'd16, 8'd8},
			'{7'd3, 7'd0, 12'd82, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd82, 3'd0, 1'b0}},
		// 45 degrees at the bottom-right corner
		'{'{sao_eo_pkg::EO_D45, DIR_OFS, 4'd8, 4'hF, 8'd16, 8'd8},
			'{7'd7, 7'd15, 12'd500, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd600, 12'd500,
				12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		// 45 degrees, last row without down neighbor
		'{'{sao_eo_pkg::EO_D45, DIR_OFS, 4'd8, 4'h7, 8'd16, 8'd8},
			'{7'd7, 7'd3, 12'd83, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd83, 3'd0, 1'b0}},
		// 12-bit depth: maximum minus 128, and a sum past the 12-bit ceiling
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd12, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd3967, 3'd4, 1'b1}},
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd12, 4'hF, 8'd16, 8'd8},
			'{7'd3, 7'd4, 12'd4000, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0,
				12'd0},
			1'b1, '{12'd4095, 3'd0, 1'b1}},
		// one column wide: column 0 is first and last, needs both flags
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h3, 8'd1, 8'd2},
			'{7'd1, 7'd0, 12'd100, 12'd0, 12'd0, 12'd50, 12'd150, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}},
		'{'{sao_eo_pkg::EO_HOR, DIR_OFS, 4'd8, 4'h1, 8'd1, 8'd2},
			'{7'd1, 7'd0, 12'd84, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{12'd84, 3'd0, 1'b0}},
		// largest block, far corner
		'{'{sao_eo_pkg::EO_D45, DIR_OFS, 4'd8, 4'hF, 8'd128, 8'd128},
			'{7'd127, 7'd127, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
				12'd0},
			1'b0, '{12'd0, 3'd0, 1'b0}}
	};

	sao_edge_offset_filter_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int sign_of(int d);
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	// Expected output for one pixel under register set k.
	function automatic sao_eo_pkg::res_t filter_pixel(sao_eo_pkg::cfg_t k,
			sao_eo_pkg::pix_in_t p);
		int w, h, bd, c, a, b, cat, sum, maxv;
		logic [sao_eo_pkg::OFS_W-1:0] ofs_byte;
		logic col_ok, row_ok, ok;
		sao_eo_pkg::res_t r;
		w  = (k.block_width > sao_eo_pkg::MAX_BLOCK_SIZE) ?
			sao_eo_pkg::MAX_BLOCK_SIZE : int'(k.block_width);
		h  = (k.block_height > sao_eo_pkg::MAX_BLOCK_SIZE) ?
			sao_eo_pkg::MAX_BLOCK_SIZE : int'(k.block_height);
		bd = (k.sample_bits > sao_eo_pkg::MAX_PIXEL_BITS) ?
			sao_eo_pkg::MAX_PIXEL_BITS : int'(k.sample_bits);
		c  = p.center_pixel;
		col_ok = (p.col != 0 || k.neighbor_avail[sao_eo_pkg::AV_LEFT]) &&
			(int'(p.col) + 1 != w || k.neighbor_avail[sao_eo_pkg::AV_RIGHT]);
		row_ok = (p.row != 0 || k.neighbor_avail[sao_eo_pkg::AV_UP]) &&
			(int'(p.row) + 1 != h || k.neighbor_avail[sao_eo_pkg::AV_DOWN]);
		ok = (int'(p.row) < h) && (int'(p.col) < w);
		case (k.eo_class)
			sao_eo_pkg::EO_HOR: begin
				a = p.left_pixel;
				b = p.right_pixel;
				ok = ok && col_ok;
			end
			sao_eo_pkg::EO_VER: begin
				a = p.up_pixel;
				b = p.down_pixel;
				ok = ok && row_ok;
			end
			sao_eo_pkg::EO_D135: begin
				a = p.up_left_pixel;
				b = p.down_right_pixel;
				ok = ok && col_ok && row_ok;
			end
			default: begin
				a = p.up_right_pixel;
				b = p.down_left_pixel;
				ok = ok && col_ok && row_ok;
			end
		endcase
		// outside the filter range: pass the centre through untouched
		if (!ok)
			return '{p.center_pixel, '0, 1'b0};
		cat = sign_of(c - a) + sign_of(c - b) + 2;
		ofs_byte = k.offset_table[sao_eo_pkg::OFS_W*cat +: sao_eo_pkg::OFS_W];
		sum = c + int'($signed(ofs_byte));
		maxv = (1 << bd) - 1;
		if (sum < 0)
			sum = 0;
		if (sum > maxv)
			sum = maxv;
		r.out_pixel = sum[sao_eo_pkg::PIX_W-1:0];
		r.edge_category = cat[sao_eo_pkg::CAT_W-1:0];
		r.filtered = 1'b1;
		return r;
	endfunction

	// Positions cluster on the block borders and just outside them.
	function automatic logic [sao_eo_pkg::POS_W-1:0] pick_pos(int limit);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return sao_eo_pkg::POS_W'(limit - 1);
			2: return sao_eo_pkg::POS_W'(limit);
			3: return sao_eo_pkg::POS_W'($urandom);
			default: return sao_eo_pkg::POS_W'($urandom_range(0, limit - 1));
		endcase
	endfunction

	// Neighbors often tie with the centre or sit one step off, so every category shows up.
	function automatic logic [sao_eo_pkg::PIX_W-1:0] near_sample(
			logic [sao_eo_pkg::PIX_W-1:0] c);
		case ($urandom_range(0, 4))
			0: return c;
			1: return c + 1'b1;
			2: return c - 1'b1;
			default: return sao_eo_pkg::PIX_W'($urandom);
		endcase
	endfunction

	function automatic sao_eo_pkg::pix_in_t rand_pixel(sao_eo_pkg::cfg_t k);
		sao_eo_pkg::pix_in_t p;
		logic [sao_eo_pkg::PIX_W-1:0] c;
		int peak;
		peak = (1 << k.sample_bits) - 1;
		case ($urandom_range(0, 3))
			0: c = sao_eo_pkg::PIX_W'($urandom_range(0, 3));
			1: c = sao_eo_pkg::PIX_W'(peak - int'($urandom_range(0, 3)));
			2: c = {sao_eo_pkg::PIX_W{1'b1}} - sao_eo_pkg::PIX_W'($urandom_range(0, 3));
			default: c = sao_eo_pkg::PIX_W'($urandom);
		endcase
		p.row = pick_pos(k.block_height);
		p.col = pick_pos(k.block_width);
		p.center_pixel = c;
		p.up_pixel = near_sample(c);
		p.down_pixel = near_sample(c);
		p.left_pixel = near_sample(c);
		p.right_pixel = near_sample(c);
		p.up_left_pixel = near_sample(c);
		p.up_right_pixel = near_sample(c);
		p.down_left_pixel = near_sample(c);
		p.down_right_pixel = near_sample(c);
		return p;
	endfunction

	function automatic sao_eo_pkg::cfg_t rand_config();
		sao_eo_pkg::cfg_t k;
		k.eo_class = sao_eo_pkg::eo_class_t'($urandom_range(0, 3));
		k.offset_table = sao_eo_pkg::CFG_DATA_W'({$urandom, $urandom});
		k.sample_bits = 4'($urandom_range(8, 12));
		k.neighbor_avail = 4'($urandom);
		case ($urandom_range(0, 3))
			0: k.block_width = 8'd1;
			1: k.block_width = 8'd128;
			default: k.block_width = 8'($urandom_range(1, 128));
		endcase
		case ($urandom_range(0, 3))
			0: k.block_height = 8'd2;
			1: k.block_height = 8'd128;
			default: k.block_height = 8'($urandom_range(2, 128));
		endcase
		return k;
	endfunction

	// Hold the write until it is taken; the caller drops cfg_valid after the last one.
	task automatic write_reg(sao_eo_pkg::cfg_reg_t idx,
			logic [sao_eo_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain the pipeline, then load every register.
	task automatic apply_config(sao_eo_pkg::cfg_t k);
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(sao_eo_pkg::REG_EO_CLASS, sao_eo_pkg::CFG_DATA_W'(k.eo_class));
		write_reg(sao_eo_pkg::REG_OFFSET_TABLE, k.offset_table);
		write_reg(sao_eo_pkg::REG_SAMPLE_BITS, sao_eo_pkg::CFG_DATA_W'(k.sample_bits));
		write_reg(sao_eo_pkg::REG_NEIGHBOR_AVAIL,
			sao_eo_pkg::CFG_DATA_W'(k.neighbor_avail));
		write_reg(sao_eo_pkg::REG_BLOCK_WIDTH, sao_eo_pkg::CFG_DATA_W'(k.block_width));
		write_reg(sao_eo_pkg::REG_BLOCK_HEIGHT, sao_eo_pkg::CFG_DATA_W'(k.block_height));
		cfg_valid <= 1'b0;
		regs = k;
	endtask

	// Offer one pixel request, with a random gap ahead of it; record the expected
	// result once the block takes it. in_valid stays high for a back-to-back request.
	task automatic push_pixel(sao_eo_pkg::pix_in_t p, bit known, sao_eo_pkg::res_t want);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{row, col, center_pixel, up_pixel, down_pixel, left_pixel, right_pixel,
			up_left_pixel, up_right_pixel, down_left_pixel, down_right_pixel} <= p;
		do @(posedge clk); while (in_stall);
		pixels_due.push_back(known ? want : filter_pixel(regs, p));
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Compare each taken result with the oldest one owed.
	always @(posedge clk) begin
		sao_eo_pkg::res_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{out_pixel, edge_category, filtered};
			if (pixels_due.size() == 0) begin
				$display("%0t: result with none expected: pixel %0d category %0d filtered %0b",
					$time, seen.out_pixel, seen.edge_category, seen.filtered);
				failures++;
			end else begin
				want = pixels_due.pop_front();
				if (seen !== want) begin
					$display({"%0t: mismatch expected pixel %0d category %0d filtered %0b,",
						" actual pixel %0d category %0d filtered %0b"}, $time,
						want.out_pixel, want.edge_category, want.filtered,
						seen.out_pixel, seen.edge_category, seen.filtered);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run when no channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_sao_edge_offset_filter_unit: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int sent, batch;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed probes under the first idle mix
		send_gap_pct = 28;
		stall_pct = 67;
		foreach (probes[i]) begin
			if (probes[i].regs != regs)
				apply_config(probes[i].regs);
			push_pixel(probes[i].px, probes[i].known, probes[i].want);
		end

		// random pixels: sender-light/receiver-heavy, the reverse, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 28;
					stall_pct = 67;
				end
				1: begin
					send_gap_pct = 67;
					stall_pct = 28;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				apply_config(rand_config());
				batch = $urandom_range(20, 60);
				repeat (batch)
					push_pixel(rand_pixel(regs), 1'b0, '0);
				sent += batch;
			end
		end

		// drain, then wait for any stray result
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (failures == 0 && pixels_due.size() == 0)
			$display("tb_sao_edge_offset_filter_unit: PASS");
		else
			$display("tb_sao_edge_offset_filter_unit: FAIL");
		$finish;
	end

endmodule
